// ===== sv/mlts_pkg.sv =====
`default_nettype none
package mlts_pkg;

  localparam int unsigned CHANNEL_COUNT_DEF = 2;
  localparam int unsigned FREQ_COUNT_DEF    = 8;
  localparam int unsigned ALPHA_COUNT_DEF   = 32;
  localparam int unsigned GAMMA_COUNT_DEF   = 6;

  localparam int LEVEL_W    = 16;
  localparam int SLOPE_W    = 15;
  localparam int LAPSE_W    = 11;
  localparam int FREQ_W     = 3;
  localparam int GAMMA_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAPSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

  localparam logic [SLOPE_W-1:0]        SLOPE_RST = 15'd4096;
  localparam logic signed [LEVEL_W-1:0] START_RST = 16'sd4096;

  localparam logic [31:0] LOG2E_Q16  = 32'd94548;
  localparam logic [31:0] LN2_Q16    = 32'd45426;
  localparam logic [12:0] TARGET_Q12 = 13'd2458;
  localparam logic [12:0] NUM_Q12    = 13'd1638;
  localparam logic [21:0] Z_LIMIT    = 22'd2097152;
  localparam logic [31:0] ONE_Q31    = 32'h8000_0000;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-(k+1)) in Q0.31 by repeated square roots of one half
  function automatic logic [31:0] root_q31(input int k);
    logic [63:0] r;
    r = 64'd1 << 30;
    for (int n = 0; n <= k; n++) r = isqrt64(r << 31);
    return r[31:0];
  endfunction

  localparam logic [31:0] ROOT_TAB [16] = '{
    root_q31(0),  root_q31(1),  root_q31(2),  root_q31(3),
    root_q31(4),  root_q31(5),  root_q31(6),  root_q31(7),
    root_q31(8),  root_q31(9),  root_q31(10), root_q31(11),
    root_q31(12), root_q31(13), root_q31(14), root_q31(15)
  };

  function automatic int alpha_q12(input int i, input int half);
    int k;
    int m;
    int a;
    k = i - half;
    m = (k < 0) ? -k : k;
    a = (m * 8192 + 5) / 10;
    return (k < 0) ? -a : a;
  endfunction

  function automatic int gamma_q12(input int j);
    return (j * 4096 + 5) / 10;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ml_psychometric_threshold_search_top.sv =====
// Likelihood mode: each of the ALPHA_COUNT*GAMMA_COUNT grid cells runs an exponent, a
// divide, a normalize and a log2 step, with all multiplies on one shared multiplier;
// the final level is then computed from the best cell.
// Staircase mode: result via res_level_q to output registers. One trial at a time.
// Reset: asynchronous, active low; a clearing pass then zeroes the likelihood memory,
// all CHANNEL_COUNT*FREQ_COUNT*ALPHA_COUNT*GAMMA_COUNT words of it, before the first trial.
`default_nettype none
module ml_psychometric_threshold_search_top #(
  parameter int unsigned CHANNEL_COUNT = mlts_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned FREQ_COUNT    = mlts_pkg::FREQ_COUNT_DEF,
  parameter int unsigned ALPHA_COUNT   = mlts_pkg::ALPHA_COUNT_DEF,
  parameter int unsigned GAMMA_COUNT   = mlts_pkg::GAMMA_COUNT_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [mlts_pkg::LEVEL_W-1:0]    level_i,
  input  logic                                   channel_i,
  input  logic [mlts_pkg::FREQ_W-1:0]            freq_index_i,
  input  logic                                   hit_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [mlts_pkg::LEVEL_W-1:0]    next_level_o,
  output logic [$clog2(ALPHA_COUNT)-1:0]         best_alpha_o,
  output logic [mlts_pkg::GAMMA_W-1:0]           best_gamma_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mlts_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mlts_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import mlts_pkg::*;

  localparam int CELLS = ALPHA_COUNT * GAMMA_COUNT;
  localparam int PLANE = FREQ_COUNT * CELLS;
  localparam int TOTAL = CHANNEL_COUNT * PLANE;
  localparam int AW    = $clog2(TOTAL);
  localparam int AIW   = $clog2(ALPHA_COUNT);
  localparam int GIW   = (GAMMA_COUNT > 1) ? $clog2(GAMMA_COUNT) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CELL, ST_Z, ST_W, ST_EXP, ST_EXP2, ST_SDIV, ST_WDIV,
    ST_P, ST_Q, ST_NORM, ST_SQ, ST_SQ2, ST_LN, ST_UPD, ST_FNUM, ST_FLN, ST_FLM,
    ST_FWAIT, ST_OUT
  } state_e;

  typedef enum logic [1:0] {LG_CELL, LG_NUM, LG_DEN} lg_ret_e;

  // constant grids
  logic signed [15:0] alpha_tab [ALPHA_COUNT];
  logic [11:0]        gamma_tab [GAMMA_COUNT];
  logic [3:0]         fr_tab    [8];

  for (genvar gi = 0; gi < ALPHA_COUNT; gi++) begin : g_alpha
    localparam int AV = alpha_q12(gi, ALPHA_COUNT / 2);
    assign alpha_tab[gi] = 16'(AV);
  end
  for (genvar gj = 0; gj < GAMMA_COUNT; gj++) begin : g_gamma
    localparam int GV = gamma_q12(gj);
    assign gamma_tab[gj] = 12'(GV);
  end
  for (genvar gf = 0; gf < 8; gf++) begin : g_freq
    localparam int FV = gf % FREQ_COUNT;
    assign fr_tab[gf] = 4'(FV);
  end

  state_e  state_q;
  lg_ret_e lg_ret_q;

  logic [SLOPE_W-1:0]        slope_q;
  logic [LAPSE_W-1:0]        lapse_q;
  logic                      mode_q;
  logic signed [15:0]        step_q;
  logic                      prev_hit_q;
  logic signed [15:0]        x_q;
  logic                      hit_q;
  logic [AW-1:0]             addr_q;
  logic [AIW-1:0]            i_q;
  logic [GIW-1:0]            j_q;
  logic                      diff_neg_q;
  logic [6:0]                n_q;
  logic [15:0]               f_q;
  logic [31:0]               r_q;
  logic [3:0]                k_q;
  logic [31:0]               y_q;
  logic [4:0]                m_q;
  logic [15:0]               frac_q;
  logic [20:0]               lnum_q;
  logic                      l_neg_q;
  logic [20:0]               l_mag_q;
  logic signed [31:0]        best_q;
  logic [AIW-1:0]            bi_q;
  logic [GIW-1:0]            bj_q;
  logic signed [15:0]        res_level_q;
  logic [AIW-1:0]            res_alpha_q;
  logic [GAMMA_W-1:0]        res_gamma_q;
  logic                      out_valid_q;
  logic signed [15:0]        next_level_q;
  logic [AIW-1:0]            best_alpha_q;
  logic [GAMMA_W-1:0]        best_gamma_q;

  logic [31:0] mem_q [TOTAL];
  logic [31:0] rd_q;
  logic        mem_we;
  logic [31:0] mem_wd;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  mlts_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .prod_o(prod));
  mlts_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // datapath terms
  logic [SLOPE_W-1:0]  beta;
  logic signed [16:0]  diff;
  logic [15:0]         mag;
  logic [32:0]         tsum;
  logic [24:0]         t_full;
  logic [21:0]         t_clamp;
  logic [38:0]         wsum;
  logic [63:0]         rsum;
  logic [31:0]         u;
  logic [12:0]         span;
  logic [32:0]         p_sum;
  logic [31:0]         p_val;
  logic [31:0]         q_raw;
  logic [31:0]         q_val;
  logic [31:0]         yy;
  logic [15:0]         frac_next;
  logic [20:0]         lg_val;
  logic [20:0]         ln_arg;
  logic [36:0]         lnsum;
  logic [20:0]         lnm;
  logic signed [32:0]  v_ext;
  logic [31:0]         v_sat;
  logic                better;
  logic signed [12:0]  num_raw;
  logic [12:0]         num_c;
  logic signed [13:0]  den_raw;
  logic [12:0]         den_c;
  logic signed [21:0]  l_diff;
  logic signed [33:0]  lv;
  logic signed [15:0]  lv_sat;
  logic signed [16:0]  half_in;
  logic signed [16:0]  half_v;
  logic signed [16:0]  step_neg;
  logic [AW-1:0]       base_addr;
  logic                ch_sel;

  always_comb begin
    beta      = (slope_q == '0) ? SLOPE_W'(1) : slope_q;
    diff      = 17'(alpha_tab[i_q]) - 17'(x_q);
    mag       = diff[16] ? 16'(-diff) : diff[15:0];
    tsum      = prod[32:0] + 33'd128;
    t_full    = tsum[32:8];
    t_clamp   = (t_full > 25'(Z_LIMIT)) ? Z_LIMIT : t_full[21:0];
    wsum      = prod[38:0] + 39'd32768;
    rsum      = prod + 64'h4000_0000;
    u         = (n_q >= 7'd32) ? 32'd0 : (r_q >> n_q[4:0]);
    span      = 13'd4096 - 13'(lapse_q) - 13'(gamma_tab[j_q]);
    p_sum     = (33'(gamma_tab[j_q]) << 19) + 33'(prod[43:12]);
    p_val     = (p_sum > 33'(ONE_Q31)) ? ONE_Q31 : p_sum[31:0];
    q_raw     = hit_q ? p_val : (ONE_Q31 - p_val);
    q_val     = (q_raw == 32'd0) ? 32'd1 : q_raw;
    yy        = prod[61:30];
    frac_next = frac_q | (yy[31] ? (16'h8000 >> k_q) : 16'd0);
    lg_val    = {m_q, frac_next};
    ln_arg    = 21'(31 << 16) - {m_q, frac_q};
    lnsum     = prod[36:0] + 37'd32768;
    lnm       = lnsum[36:16];
    v_ext     = {rd_q[31], rd_q} - {12'd0, lnm};
    v_sat     = (v_ext[32] != v_ext[31]) ? 32'h8000_0000 : v_ext[31:0];
    better    = (i_q == '0 && j_q == '0) || ($signed(v_sat) > best_q);
    num_raw   = $signed(NUM_Q12) - $signed({2'b00, lapse_q});
    num_c     = (num_raw < 13'sd1) ? 13'd1 : num_raw;
    den_raw   = $signed({1'b0, TARGET_Q12}) - $signed({2'b00, gamma_tab[bj_q]});
    den_c     = (den_raw < 14'sd1) ? 13'd1 : den_raw[12:0];
    l_diff    = $signed({1'b0, lnum_q}) - $signed({1'b0, lg_val});
    lv        = l_neg_q ? (34'(alpha_tab[bi_q]) + $signed({2'b00, div_rsp.quotient}))
                        : (34'(alpha_tab[bi_q]) - $signed({2'b00, div_rsp.quotient}));
    if (lv > 34'sd32767)       lv_sat = 16'sh7FFF;
    else if (lv < -34'sd32768) lv_sat = 16'sh8000;
    else                       lv_sat = lv[15:0];
    half_in   = 17'(step_q) + 17'(step_q[15]);
    half_v    = half_in >>> 1;
    step_neg  = -half_v;
    ch_sel    = (CHANNEL_COUNT > 1) ? channel_i : 1'b0;
    base_addr = AW'(int'(ch_sel) * PLANE + int'(fr_tab[freq_index_i]) * CELLS);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CELL: begin
        mul_a = 32'(mag);
        mul_b = 32'(beta);
      end
      ST_Z: begin
        mul_a = 32'(t_clamp);
        mul_b = LOG2E_Q16;
      end
      ST_EXP: begin
        mul_a = r_q;
        mul_b = f_q[4'd15 - k_q] ? ROOT_TAB[k_q] : ONE_Q31;
      end
      ST_P: begin
        mul_a = div_rsp.quotient;
        mul_b = 32'(span);
      end
      ST_SQ: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      ST_LN: begin
        mul_a = 32'(ln_arg);
        mul_b = LN2_Q16;
      end
      ST_FLN: begin
        mul_a = 32'(l_mag_q);
        mul_b = LN2_Q16;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = (state_q == ST_SDIV) || (state_q == ST_FLM);
    div_req.dividend = '0;
    div_req.divisor  = 33'(beta);
    if (state_q == ST_SDIV) begin
      div_req.dividend = diff_neg_q ? (64'd1 << 62) : (64'(u) << 31);
      div_req.divisor  = 33'(ONE_Q31) + 33'(u);
    end else begin
      div_req.dividend = (64'(lnm) << 8) + 64'(beta >> 1);
    end
  end

  assign mem_we = (state_q == ST_CLEAR) || (state_q == ST_UPD);
  assign mem_wd = (state_q == ST_CLEAR) ? 32'd0 : v_sat;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr_q] <= mem_wd;
    if (state_q == ST_CELL) rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      lg_ret_q    <= LG_CELL;
      addr_q      <= '0;
      slope_q     <= SLOPE_RST;
      lapse_q     <= '0;
      mode_q      <= 1'b0;
      step_q      <= START_RST;
      prev_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SLOPE: slope_q <= cfg_data_i[SLOPE_W-1:0];
          CFG_LAPSE: lapse_q <= cfg_data_i[LAPSE_W-1:0];
          CFG_MODE:  mode_q  <= cfg_data_i[0];
          default: ; // index 3 is ignored; the step starts from START_RST
        endcase
      end
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i)                    out_valid_q <= 1'b0;

      case (state_q)
        ST_CLEAR: begin
          if (addr_q == AW'(TOTAL - 1)) state_q <= ST_IDLE;
          addr_q <= addr_q + AW'(1);
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            if (mode_q) begin
              if (level_i <= 16'sd0 || hit_i != prev_hit_q) begin
                step_q      <= step_neg[15:0];
                res_level_q <= step_neg[15:0];
              end else begin
                res_level_q <= step_q;
              end
              prev_hit_q  <= hit_i;
              res_alpha_q <= '0;
              res_gamma_q <= '0;
              state_q     <= ST_OUT;
            end else begin
              x_q     <= level_i;
              hit_q   <= hit_i;
              addr_q  <= base_addr;
              i_q     <= '0;
              j_q     <= '0;
              state_q <= ST_CELL;
            end
          end
        end
        ST_CELL: begin
          diff_neg_q <= diff[16];
          state_q    <= ST_Z;
        end
        ST_Z: state_q <= ST_W;
        ST_W: begin
          n_q     <= wsum[38:32];
          f_q     <= wsum[31:16];
          r_q     <= ONE_Q31;
          k_q     <= '0;
          state_q <= ST_EXP;
        end
        ST_EXP: state_q <= ST_EXP2;
        ST_EXP2: begin
          r_q <= rsum[62:31];
          k_q <= k_q + 4'd1;
          state_q <= (k_q == 4'd15) ? ST_SDIV : ST_EXP;
        end
        ST_SDIV: state_q <= ST_WDIV;
        ST_WDIV: if (div_rsp.done) state_q <= ST_P;
        ST_P: state_q <= ST_Q;
        ST_Q: begin
          y_q      <= q_val;
          m_q      <= 5'd31;
          lg_ret_q <= LG_CELL;
          state_q  <= ST_NORM;
        end
        ST_NORM: begin
          if (y_q[31]) begin
            y_q     <= {1'b0, y_q[31:1]};
            k_q     <= '0;
            frac_q  <= '0;
            state_q <= ST_SQ;
          end else begin
            y_q <= {y_q[30:0], 1'b0};
            m_q <= m_q - 5'd1;
          end
        end
        ST_SQ: state_q <= ST_SQ2;
        ST_SQ2: begin
          frac_q <= frac_next;
          k_q    <= k_q + 4'd1;
          if (k_q == 4'd15) begin
            case (lg_ret_q)
              LG_CELL: state_q <= ST_LN;
              LG_NUM: begin
                lnum_q   <= lg_val;
                y_q      <= 32'(den_c);
                m_q      <= 5'd31;
                lg_ret_q <= LG_DEN;
                state_q  <= ST_NORM;
              end
              default: begin
                l_neg_q <= l_diff[21];
                l_mag_q <= l_diff[21] ? 21'(-l_diff) : l_diff[20:0];
                state_q <= ST_FLN;
              end
            endcase
          end else begin
            y_q     <= yy[31] ? {1'b0, yy[31:1]} : yy;
            state_q <= ST_SQ;
          end
        end
        ST_LN: state_q <= ST_UPD;
        ST_UPD: begin
          if (better) begin
            best_q <= $signed(v_sat);
            bi_q   <= i_q;
            bj_q   <= j_q;
          end
          addr_q <= addr_q + AW'(1);
          if (j_q == GIW'(GAMMA_COUNT - 1)) begin
            j_q <= '0;
            i_q <= i_q + AIW'(1);
            state_q <= (i_q == AIW'(ALPHA_COUNT - 1)) ? ST_FNUM : ST_CELL;
          end else begin
            j_q     <= j_q + GIW'(1);
            state_q <= ST_CELL;
          end
        end
        ST_FNUM: begin
          y_q      <= 32'(num_c);
          m_q      <= 5'd31;
          lg_ret_q <= LG_NUM;
          state_q  <= ST_NORM;
        end
        ST_FLN: state_q <= ST_FLM;
        ST_FLM: state_q <= ST_FWAIT;
        ST_FWAIT: begin
          if (div_rsp.done) begin
            res_level_q <= lv_sat;
            res_alpha_q <= bi_q;
            res_gamma_q <= GAMMA_W'(bj_q);
            state_q     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            next_level_q <= res_level_q;
            best_alpha_q <= res_alpha_q;
            best_gamma_q <= res_gamma_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign next_level_o = next_level_q;
  assign best_alpha_o = best_alpha_q;
  assign best_gamma_o = best_gamma_q;
endmodule
`default_nettype wire

// ===== sv/mlts_mul.sv =====
`default_nettype none
module mlts_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);
  always_ff @(posedge clk_i) begin
    prod_o <= 64'(a_i) * 64'(b_i);
  end
endmodule
`default_nettype wire

// ===== sv/mlts_div.sv =====
`default_nettype none
module mlts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlts_pkg::div_req_t req_i,
  output mlts_pkg::div_rsp_t rsp_o
);
  import mlts_pkg::*;

  // restoring divider, one quotient bit per cycle; needs dividend[63:32] < divisor
  logic [32:0] rem_q;
  logic [31:0] quo_q;
  logic [32:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [33:0] trial;
  logic        take;

  assign trial = {rem_q, quo_q[31]};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.dividend[63:32]};
      quo_q <= req_i.dividend[31:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= take ? 33'(trial - {1'b0, dvs_q}) : trial[32:0];
      quo_q <= {quo_q[30:0], take};
    end
  end

  assign rsp_o = '{done: done_q, quotient: quo_q};
endmodule
`default_nettype wire

// ===== sv/mlts_chk.sv =====
`default_nettype none
module mlts_chk #(
  parameter int unsigned ALPHA_COUNT = 32,
  parameter int unsigned GAMMA_COUNT = 6
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [15:0]                    next_level_o,
  input logic [$clog2(ALPHA_COUNT)-1:0] best_alpha_o,
  input logic [2:0]                     best_gamma_o
);
  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_level_o)
      && $stable(best_alpha_o) && $stable(best_gamma_o))
    else $error("stalled result changed");

  // one trial at a time
  a_one_trial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted while busy");

  a_gamma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(best_gamma_o) < GAMMA_COUNT)
    else $error("gamma index out of grid");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(best_alpha_o) < ALPHA_COUNT)
    else $error("alpha index out of grid");
endmodule

bind ml_psychometric_threshold_search_top mlts_chk #(
  .ALPHA_COUNT(ALPHA_COUNT),
  .GAMMA_COUNT(GAMMA_COUNT)
) u_mlts_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .next_level_o(next_level_o),
  .best_alpha_o(best_alpha_o),
  .best_gamma_o(best_gamma_o)
);
`default_nettype wire

// ===== verif/ml_psychometric_threshold_search_top_test.sv =====
`timescale 1ns / 1ps
module ml_psychometric_threshold_search_top_test;
  import mlts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd3;
  localparam int NCH = 2;
  localparam int NFR = 8;
  localparam int NAL = 32;
  localparam int NGA = 6;
  localparam longint ONE31 = 64'sd1 << 31;

  typedef struct {
    logic signed [15:0] level;
    logic               channel;
    logic [2:0]         freq;
    logic               hit;
  } trial_t;

  typedef struct {
    logic signed [15:0] next_level;
    logic [4:0]         alpha;
    logic [2:0]         gamma;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] level = '0;
  logic channel = 1'b0;
  logic [2:0] freq_index = '0;
  logic hit = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] next_level;
  logic [4:0] best_alpha;
  logic [2:0] best_gamma;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  trial_t    pending_trials[$];
  estimate_t expected_estimates[$];
  int        errors = 0;

  int unsigned m_slope = 4096;
  int unsigned m_lapse = 0;
  int unsigned m_mode = 0;
  int          step_size = 4096;
  logic        prev_hit = 1'b0;
  int          log_lik[NCH*NFR*NAL*NGA];
  longint      half_roots[16];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ml_psychometric_threshold_search_top i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .level_i(level), .channel_i(channel), .freq_index_i(freq_index), .hit_i(hit),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .next_level_o(next_level), .best_alpha_o(best_alpha), .best_gamma_o(best_gamma),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic longint int_sqrt(longint v);
    longint res;
    longint bt;
    res = 0;
    bt = 64'sd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint log2_fix(longint v);
    int m;
    longint y;
    longint fr;
    if (v < 1) v = 1;
    m = 62;
    while (((v >> m) & 1) == 0) m--;
    y = (m > 30) ? (v >> (m - 30)) : (v << (30 - m));
    fr = 0;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'sd2 << 30)) begin
        y = y >> 1;
        fr = fr | (64'sd1 << b);
      end
    end
    return (longint'(m) << 16) | fr;
  endfunction

  function automatic longint exp_neg_fix(longint t);
    longint w;
    longint n;
    longint f;
    longint r;
    if (t > (64'sd32 << 16)) t = 64'sd32 << 16;
    w = (t * 94548 + 32768) >> 16;
    n = w >> 16;
    f = w & 16'hFFFF;
    r = ONE31;
    for (int k = 0; k < 16; k++)
      if ((f & (32'h8000 >> k)) != 0) r = (r * half_roots[k] + (64'sd1 << 30)) >> 31;
    return (n >= 32) ? 0 : (r >> n);
  endfunction

  function automatic longint ln_fix(longint m);
    return (m * 45426 + 32768) >> 16;
  endfunction

  function automatic int alpha_level(int i);
    int k;
    int a;
    k = i - NAL / 2;
    a = (((k < 0) ? -k : k) * 8192 + 5) / 10;
    return (k < 0) ? -a : a;
  endfunction

  function automatic int gamma_floor(int j);
    return (j * 4096 + 5) / 10;
  endfunction

  function automatic estimate_t update_estimate(trial_t t);
    estimate_t e;
    int x;
    int base;
    int bi;
    int bj;
    int best;
    int a;
    int g;
    int num;
    int den;
    longint beta;
    longint diff;
    longint u;
    longint s;
    longint p;
    longint q;
    longint v;
    longint lq;
    longint dm;
    longint d;
    x = t.level;
    beta = (m_slope == 0) ? 1 : m_slope;
    if (m_mode == 1) begin
      if (x <= 0 || t.hit != prev_hit) step_size = -(step_size / 2);
      prev_hit = t.hit;
      e.next_level = step_size[15:0];
      e.alpha = '0;
      e.gamma = '0;
      return e;
    end
    base = ((int'(t.channel) % NCH) * NFR + (int'(t.freq) % NFR)) * NAL * NGA;
    bi = 0;
    bj = 0;
    best = 0;
    for (int i = 0; i < NAL; i++) begin
      for (int j = 0; j < NGA; j++) begin
        diff = alpha_level(i) - x;
        u = exp_neg_fix((((diff < 0) ? -diff : diff) * beta + 128) >> 8);
        s = (diff >= 0) ? (u << 31) / (ONE31 + u) : (ONE31 << 31) / (ONE31 + u);
        g = gamma_floor(j);
        p = (longint'(g) << 19) + ((longint'(4096 - int'(m_lapse) - g) * s) >> 12);
        if (p > ONE31) p = ONE31;
        q = t.hit ? p : ONE31 - p;
        if (q < 1) q = 1;
        v = longint'(log_lik[base + i*NGA + j]) - ln_fix((64'sd31 << 16) - log2_fix(q));
        if (v < -(64'sd1 << 31)) v = -(64'sd1 << 31);
        log_lik[base + i*NGA + j] = int'(v);
        if ((i == 0 && j == 0) || int'(v) > best) begin
          best = int'(v);
          bi = i;
          bj = j;
        end
      end
    end
    a = alpha_level(bi);
    g = gamma_floor(bj);
    num = 4096 - 2458 - int'(m_lapse);
    if (num < 1) num = 1;
    den = 2458 - g;
    if (den < 1) den = 1;
    lq = log2_fix(num) - log2_fix(den);
    dm = (ln_fix((lq < 0) ? -lq : lq) * 256 + beta / 2) / beta;
    d = (lq < 0) ? -dm : dm;
    v = longint'(a) - d;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    e.next_level = v[15:0];
    e.alpha = bi[4:0];
    e.gamma = bj[2:0];
    return e;
  endfunction

  // driver
  int  send_gap = 0;
  bit  send_burst = 0;
  always @(posedge clk_i) begin
    logic   vld_n;
    trial_t t;
    vld_n = in_valid;
    if (in_valid && !in_stall) begin
      t.level = level;
      t.channel = channel;
      t.freq = freq_index;
      t.hit = hit;
      expected_estimates.push_back(update_estimate(t));
      vld_n = 1'b0;
      if ($urandom_range(0, 30) == 0) send_burst = !send_burst;
      send_gap = send_burst ? 0 : $urandom_range(0, 4);
    end
    if (!vld_n && rst_ni) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_trials.size() > 0) begin
        t = pending_trials.pop_front();
        level <= t.level;
        channel <= t.channel;
        freq_index <= t.freq;
        hit <= t.hit;
        vld_n = 1'b1;
      end
    end
    in_valid <= vld_n;
  end

  // monitor
  int  stall_left = 0;
  bit  recv_burst = 0;
  always @(posedge clk_i) begin
    estimate_t e;
    if (out_valid && !out_stall) begin
      if (expected_estimates.size() == 0) begin
        $error("unexpected result transaction, next_level %0d", next_level);
        errors++;
      end else begin
        e = expected_estimates.pop_front();
        if (next_level !== e.next_level) begin
          $error("next_level expected %0d actual %0d", e.next_level, next_level);
          errors++;
        end
        if (best_alpha !== e.alpha) begin
          $error("best_alpha expected %0d actual %0d", e.alpha, best_alpha);
          errors++;
        end
        if (best_gamma !== e.gamma) begin
          $error("best_gamma expected %0d actual %0d", e.gamma, best_gamma);
          errors++;
        end
      end
      if ($urandom_range(0, 30) == 0) recv_burst = !recv_burst;
      stall_left = recv_burst ? 0 : $urandom_range(0, 4);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_trials.size() != 0 || in_valid || expected_estimates.size() != 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    do @(posedge clk_i);
    while (!cfg_ready);
    case (idx)
      CFG_SLOPE: m_slope = value & 16'h7FFF;
      CFG_LAPSE: m_lapse = value & 16'h07FF;
      CFG_MODE:  m_mode = value & 1;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int slope, int lapse, int mode, int start);
    wait_idle();
    write_reg(CFG_SLOPE, slope);
    write_reg(CFG_LAPSE, lapse);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_START, start);
  endtask

  task automatic push_trial(int lvl, int ch, int fr, int h);
    trial_t t;
    t.level = lvl[15:0];
    t.channel = ch[0];
    t.freq = fr[2:0];
    t.hit = h[0];
    pending_trials.push_back(t);
  endtask

  task automatic push_random_trials(int n, bit staircase);
    int ch;
    int fr;
    int center;
    int lvl;
    ch = $urandom_range(0, 1);
    fr = $urandom_range(0, 7);
    center = $urandom_range(0, 12000) - 6000;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        lvl = $urandom_range(0, 65535) - 32768;
        push_trial(lvl, $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 1));
      end else begin
        lvl = center + $urandom_range(0, 4000) - 2000;
        if (staircase) lvl = $urandom_range(0, 3) == 0 ? -lvl : lvl;
        push_trial(lvl, ch, fr, (lvl > center) ? ($urandom_range(0, 7) != 0)
                                               : ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    longint r;
    r = ONE31 >> 1;
    for (int k = 0; k < 16; k++) begin
      r = int_sqrt(r << 31);
      half_roots[k] = r;
    end
    foreach (log_lik[n]) log_lik[n] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_trial(-32768, 0, 0, 0);
    push_trial(32767, 1, 7, 1);
    push_trial(0, 0, 7, 1);
    push_trial(4096, 1, 0, 0);
    push_trial(-4096, 0, 3, 1);
    configure(32767, 1637, 0, -32768);
    push_trial(32767, 0, 0, 1);
    push_trial(-32768, 1, 7, 0);
    push_trial(1000, 0, 0, 1);
    configure(0, 2047, 0, 32767);
    push_trial(2000, 1, 5, 1);
    push_trial(-2000, 1, 5, 0);
    push_trial(-32768, 0, 2, 1);
    configure(1, 0, 0, 0);
    push_trial(32767, 0, 1, 0);
    push_trial(-32768, 1, 6, 1);
    configure(4096, 0, 1, 4096);
    push_trial(100, 0, 0, 0);
    push_trial(100, 0, 0, 1);
    push_trial(100, 0, 0, 1);
    push_trial(0, 1, 7, 1);
    push_trial(-32768, 0, 0, 0);
    push_trial(32767, 1, 1, 0);
    push_trial(5, 0, 0, 1);

    for (int ph = 0; ph < 10; ph++) begin
      configure($urandom_range(0, 4) == 0 ? $urandom_range(0, 32767)
                                          : $urandom_range(1024, 12000),
                $urandom_range(0, 4) == 0 ? $urandom_range(0, 2047)
                                          : $urandom_range(0, 1637),
                0, $urandom_range(0, 65535));
      push_random_trials(4, 1'b0);
      configure($urandom_range(0, 32767), $urandom_range(0, 2047), 1,
                $urandom_range(0, 65535));
      push_random_trials(115, 1'b1);
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("ml_psychometric_threshold_search_top_test: clean");
    else $display("ml_psychometric_threshold_search_top_test: errors");
    $finish;
  end

  initial begin
    #150_000_000;
    $display("ml_psychometric_threshold_search_top_test: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mlts_pkg.sv
sv/mlts_mul.sv
sv/mlts_div.sv
sv/ml_psychometric_threshold_search_top.sv
sv/mlts_chk.sv
verif/ml_psychometric_threshold_search_top_test.sv
